/* hw/rtl/nrsr_pkg.sv */
// ----------------------------------------------------------------------------
// nrsr_pkg
// Shared widths and the command/status bundles that join the run splitter's
// controller and datapath.
// ----------------------------------------------------------------------------
package nrsr_pkg;

  // Fixed field widths at the ports
  localparam int VALUE_W = 8;
  localparam int LEN_W   = 6;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted input word
    logic append;      // add held word to the open run
    logic start_new;   // held word opens a fresh run at entry 0
    logic emit_init;   // begin emitting the open run
    logic emit_final;  // with emit_init: this emission ends the stream
    logic emit_load;   // move one buffered element into the output register
  } nrsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic brk;         // held word breaks the open run's direction
    logic fill;        // appending the held word fills the run
    logic hold_last;   // held word carries last_item
    logic out_free;    // output register can take a word this cycle
    logic emit_last;   // element being emitted is the run's final one
  } nrsr_status_t;

endpackage

/* hw/rtl/nrsr_ram.sv */
// ----------------------------------------------------------------------------
// nrsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nrsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/nrsr_datapath.sv */
// ----------------------------------------------------------------------------
// nrsr_datapath
// Run buffer, direction tracking, emit address generation and the output
// register of the run splitter.
// ----------------------------------------------------------------------------
module nrsr_datapath
  import nrsr_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int RUN_DEPTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  nrsr_cmd_t          cmd,
  output nrsr_status_t       status,
  input  logic [VALUE_W-1:0] value,
  input  logic               last_item,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_value,
  output logic [LEN_W-1:0]   run_length,
  output logic               run_reversed,
  output logic               run_end,
  output logic               stream_end
);

  localparam int CW = $clog2(RUN_DEPTH + 1);
  localparam int IW = $clog2(RUN_DEPTH);

  logic [DATA_WIDTH-1:0] hold_value;
  logic                  hold_last;
  logic [DATA_WIDTH-1:0] prev_value;
  logic                  asc;
  logic                  asc_next;
  logic [CW-1:0]         count;
  logic [IW-1:0]         emit_idx;
  logic                  emit_rev;
  logic                  emit_final;

  logic                  fits;
  logic                  emit_last;
  logic [CW-1:0]         rev_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [IW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  // Direction check of the held word against the open run
  assign fits = asc ? (prev_value <= hold_value) : (prev_value >= hold_value);

  // Second element of a run fixes its direction; stream end restores ascending
  always_comb begin
    asc_next = asc;
    if (cmd.append && (count == CW'(1))) begin
      asc_next = (prev_value <= hold_value);
    end else if (cmd.emit_load && emit_last && emit_final) begin
      asc_next = 1'b1;
    end
  end

  // Emit order: reversed runs read from the top down
  assign rev_addr  = count - CW'(1) - CW'(emit_idx);
  assign rd_addr   = emit_rev ? rev_addr[IW-1:0] : emit_idx;
  assign emit_last = (CW'(emit_idx) == (count - CW'(1)));

  // Buffer write: append at the fill point, a new run at entry 0
  assign wr_en   = cmd.append || cmd.start_new;
  assign wr_addr = cmd.start_new ? '0 : count[IW-1:0];

  nrsr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (RUN_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (hold_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status back to the controller
  always_comb begin
    status.brk       = (count > CW'(1)) && !fits;
    status.fill      = (count == CW'(RUN_DEPTH - 1));
    status.hold_last = hold_last;
    status.out_free  = !out_valid || !out_stall;
    status.emit_last = emit_last;
  end

  // Held input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_value <= DATA_WIDTH'(value);
      hold_last  <= last_item;
    end
  end

  // Run state: count, previous word, direction
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      prev_value <= '0;
      asc        <= 1'b1;
    end else begin
      asc <= asc_next;
      if (cmd.append) begin
        count      <= count + CW'(1);
        prev_value <= hold_value;
      end else if (cmd.start_new) begin
        count      <= CW'(1);
        prev_value <= hold_value;
      end else if (cmd.emit_load && emit_last) begin
        count <= '0;
        if (emit_final) begin
          prev_value <= '0;
        end
      end
    end
  end

  // Emit pointer and run flags
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      emit_idx   <= '0;
      emit_rev   <= !asc_next;
      emit_final <= cmd.emit_final;
    end else if (cmd.emit_load) begin
      emit_idx <= emit_idx + IW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_value    <= rd_data[VALUE_W-1:0];
      run_length   <= LEN_W'(count);
      run_reversed <= emit_rev;
      run_end      <= emit_last;
      stream_end   <= emit_last && emit_final;
    end
  end

endmodule

/* hw/rtl/nrsr_ctrl.sv */
// ----------------------------------------------------------------------------
// nrsr_ctrl
// Sequencer of the run splitter: takes a word, classifies it against the
// open run and steps the datapath through run emission.
// ----------------------------------------------------------------------------
module nrsr_ctrl
  import nrsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  nrsr_status_t status,
  output nrsr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    STEP,
    EMIT_ADDR,
    EMIT_LOAD,
    START_NEW
  } state_t;

  state_t state;
  state_t state_next;
  logic   after_break;
  logic   after_break_next;

  assign in_stall = rst || (state != IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next       = state;
    after_break_next = after_break;
    cmd              = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = STEP;
        end
      end
      STEP: begin
        if (status.brk) begin
          // emit the closed run before the held word opens a new one
          cmd.emit_init    = 1'b1;
          after_break_next = 1'b1;
          state_next       = EMIT_ADDR;
        end else begin
          cmd.append = 1'b1;
          if (status.fill || status.hold_last) begin
            cmd.emit_init    = 1'b1;
            cmd.emit_final   = status.hold_last;
            after_break_next = 1'b0;
            state_next       = EMIT_ADDR;
          end else begin
            state_next = IDLE;
          end
        end
      end
      EMIT_ADDR: begin
        state_next = EMIT_LOAD;
      end
      EMIT_LOAD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            state_next = after_break ? START_NEW : IDLE;
          end else begin
            state_next = EMIT_ADDR;
          end
        end
      end
      START_NEW: begin
        cmd.start_new    = 1'b1;
        after_break_next = 1'b0;
        if (status.hold_last) begin
          // one-element run flushed by last_item
          cmd.emit_init  = 1'b1;
          cmd.emit_final = 1'b1;
          state_next     = EMIT_ADDR;
        end else begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      after_break <= 1'b0;
    end else begin
      state       <= state_next;
      after_break <= after_break_next;
    end
  end

endmodule

/* hw/rtl/natural_run_splitter_reverser.sv */
// ----------------------------------------------------------------------------
// natural_run_splitter_reverser
// Splits a word stream into maximal monotone runs, cut at RUN_DEPTH words, and
// emits each closed run in ascending order, with its length and reversed flag.
//
//   channel | direction | handshake           | words
//   in      | input     | in_valid / in_stall   | value, last_item
//   out     | output    | out_valid / out_stall | out_value, run_length,
//           |           |                       | run_reversed, run_end,
//           |           |                       | stream_end
//
// An input word is accepted in IDLE and classified in STEP; a break adds START_NEW.
// A closing run emits each element through EMIT_ADDR, for the buffer RAM's
// registered read, then EMIT_LOAD, which out_stall holds while a word waits.
// in_stall stays high while a word is classified or a run is emitted.
// Reset is synchronous; the run buffer is not cleared, count starts at 0.
// ----------------------------------------------------------------------------
module natural_run_splitter_reverser
  import nrsr_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int RUN_DEPTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_value,
  output logic [LEN_W-1:0]   run_length,
  output logic               run_reversed,
  output logic               run_end,
  output logic               stream_end
);

  nrsr_cmd_t    cmd;
  nrsr_status_t status;

  nrsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  nrsr_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .RUN_DEPTH  (RUN_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .last_item    (last_item),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .run_length   (run_length),
    .run_reversed (run_reversed),
    .run_end      (run_end),
    .stream_end   (stream_end)
  );

endmodule

/* hw/rtl/nrsr_checker.sv */
// ----------------------------------------------------------------------------
// nrsr_props
// Port-level checks on the run splitter, bound to the top level.
// ----------------------------------------------------------------------------
module nrsr_props
  import nrsr_pkg::*;
#(
  parameter int RUN_DEPTH = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [VALUE_W-1:0] out_value,
  input logic [LEN_W-1:0]   run_length,
  input logic               run_reversed,
  input logic               run_end,
  input logic               stream_end
);

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(run_length) && $stable(run_reversed) && $stable(run_end) &&
      $stable(stream_end))
    else $error("stalled output word changed");

  // Stream end only on a run's final word
  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_end)
    else $error("stream_end without run_end");

  // Run length within the buffer depth
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_length != '0) && (run_length <= LEN_W'(RUN_DEPTH)))
    else $error("run length out of range");

  // Input is held off while a run is emitted
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_end |-> in_stall)
    else $error("input accepted in the middle of a run");

endmodule

bind natural_run_splitter_reverser nrsr_props #(.RUN_DEPTH(RUN_DEPTH)) u_nrsr_props (.*);
